FILE: hw/rtl/bal_pkg.sv
// ============================================================================
// bal_pkg
// Shared types and constants of the bounded array list.
// ============================================================================
package bal_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int DATA_W       = 32;
   localparam int POS_W        = 4;
   localparam int COUNT_W      = 5;

   typedef enum logic [1:0] {
      REQ_APPEND       = 2'd0,
      REQ_REMOVE_LAST  = 2'd1,
      REQ_REMOVE_FIRST = 2'd2,
      REQ_SEARCH       = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SCAN,
      S_FIN
   } state_type;

endpackage

FILE: hw/rtl/bounded_array_list.sv
// Steps: append, full, empty and empty-search go from S_IDLE to S_FIN;
// removals read the entry in S_READ first; a search walks S_SCAN to the first
// match or the item count. S_FIN loads the result register once it is free.
// A new request is taken only in S_IDLE, after the last result is loaded; a
// search walks the single read port of the entry memory one entry per cycle.
// Reset clears count, total and head pointer; the entry memory is not cleared.
// ============================================================================
// bounded_array_list
// Fixed-capacity list of 32-bit words kept as a ring in one synchronous
// memory: append, remove last, remove first, and linear search.
// ============================================================================
module bounded_array_list #(
   parameter int CAPACITY = bal_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_type,
   input  logic signed [bal_pkg::DATA_W-1:0]    req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_found,
   output logic [bal_pkg::POS_W-1:0]            rsp_position,
   output logic signed [bal_pkg::DATA_W-1:0]    rsp_removed_value,
   output logic [bal_pkg::COUNT_W-1:0]          rsp_item_count,
   output logic signed [bal_pkg::DATA_W-1:0]    rsp_sum_of_items
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = CW + 1;
   localparam int DW = bal_pkg::DATA_W;

   bal_pkg::state_type    state_ff, state_in;
   bal_pkg::req_kind_type kind_ff, kind_in;
   bal_pkg::req_kind_type req_kind;
   bal_pkg::status_type   stat_ff, stat_in;
   logic [DW-1:0]         val_ff, val_in;
   logic                  found_ff, found_in;
   logic [IW-1:0]         pos_ff, pos_in;
   logic [DW-1:0]         rem_ff, rem_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DW-1:0]         sum_ff, sum_in;
   logic [IW-1:0]         head_ff, head_in;
   logic [CW-1:0]         scan_ff, scan_in;
   logic [CW-1:0]         scan_next;
   logic [DW-1:0]         rd_data_ff;
   logic [DW-1:0]         entries_ff [0:CAPACITY-1];

   logic [CW-1:0]         idx_sel;
   logic [AW-1:0]         addr_sum;
   logic [AW-1:0]         addr_wrap;
   logic [IW-1:0]         addr;
   logic                  mem_we;
   logic                  load_rsp;
   logic                  out_free;
   logic                  is_full;
   logic                  is_empty;

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic                  rsp_found_ff;
   logic [bal_pkg::POS_W-1:0]   rsp_position_ff;
   logic [DW-1:0]         rsp_removed_ff;
   logic [bal_pkg::COUNT_W-1:0] rsp_count_ff;
   logic [DW-1:0]         rsp_sum_ff;

   assign req_kind  = bal_pkg::req_kind_type'(req_type);
   assign is_full   = (count_ff == CW'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_next = scan_ff + CW'(1);

   // logical index to select for this cycle's memory access
   always_comb begin
      idx_sel = '0;
      case (state_ff)
         bal_pkg::S_IDLE: begin
            case (req_kind)
               bal_pkg::REQ_APPEND:      idx_sel = count_ff;
               bal_pkg::REQ_REMOVE_LAST: idx_sel = count_ff - CW'(1);
               default:                  idx_sel = '0;
            endcase
         end
         bal_pkg::S_READ: idx_sel = CW'(1);
         bal_pkg::S_SCAN: idx_sel = scan_next;
         default:         idx_sel = '0;
      endcase
   end

   assign addr_sum  = AW'(head_ff) + AW'(idx_sel);
   assign addr_wrap = (addr_sum >= AW'(CAPACITY)) ? (addr_sum - AW'(CAPACITY)) : addr_sum;
   assign addr      = IW'(addr_wrap);

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      stat_in   = stat_ff;
      val_in    = val_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;
      rem_in    = rem_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      head_in   = head_ff;
      scan_in   = scan_ff;
      mem_we    = 1'b0;
      load_rsp  = 1'b0;
      req_stall = (state_ff != bal_pkg::S_IDLE);
      case (state_ff)
         bal_pkg::S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               val_in   = req_value;
               stat_in  = bal_pkg::STATUS_OK;
               found_in = 1'b0;
               pos_in   = '0;
               rem_in   = '0;
               scan_in  = '0;
               state_in = bal_pkg::S_FIN;
               case (req_kind)
                  bal_pkg::REQ_APPEND: begin
                     if (is_full) begin
                        stat_in = bal_pkg::STATUS_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                        sum_in   = sum_ff + req_value;
                     end
                  end
                  bal_pkg::REQ_REMOVE_LAST: begin
                     if (is_empty) begin
                        stat_in = bal_pkg::STATUS_EMPTY;
                     end else begin
                        pos_in   = IW'(count_ff - CW'(1));
                        state_in = bal_pkg::S_READ;
                     end
                  end
                  bal_pkg::REQ_REMOVE_FIRST: begin
                     if (is_empty) begin
                        stat_in = bal_pkg::STATUS_EMPTY;
                     end else begin
                        state_in = bal_pkg::S_READ;
                     end
                  end
                  default: begin
                     if (!is_empty) begin
                        state_in = bal_pkg::S_SCAN;
                     end
                  end
               endcase
            end
         end
         bal_pkg::S_READ: begin
            rem_in   = rd_data_ff;
            count_in = count_ff - CW'(1);
            sum_in   = sum_ff - rd_data_ff;
            if (kind_ff == bal_pkg::REQ_REMOVE_FIRST) begin
               head_in = addr;
            end
            state_in = bal_pkg::S_FIN;
         end
         bal_pkg::S_SCAN: begin
            if (rd_data_ff == val_ff) begin
               found_in = 1'b1;
               pos_in   = IW'(scan_ff);
               state_in = bal_pkg::S_FIN;
            end else if (scan_next == count_ff) begin
               state_in = bal_pkg::S_FIN;
            end else begin
               scan_in = scan_next;
            end
         end
         bal_pkg::S_FIN: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = bal_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bal_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bal_pkg::S_IDLE;
         count_ff <= '0;
         sum_ff   <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      stat_ff  <= stat_in;
      val_ff   <= val_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
      rem_ff   <= rem_in;
      scan_ff  <= scan_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_ff[addr] <= req_value;
      end
      rd_data_ff <= entries_ff[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff   <= stat_ff;
         rsp_found_ff    <= found_ff;
         rsp_position_ff <= bal_pkg::POS_W'(pos_ff);
         rsp_removed_ff  <= rem_ff;
         rsp_count_ff    <= bal_pkg::COUNT_W'(count_ff);
         rsp_sum_ff      <= sum_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_item_count    = rsp_count_ff;
   assign rsp_sum_of_items  = rsp_sum_ff;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the bounded array list. A driver offers append,
// remove and search requests from a pending queue, a shadow list predicts
// every result at the request beat, and a monitor compares each result beat
// field by field. Both sides idle at random, and the receiver holds off for
// long stretches to back the block up.
// ============================================================================
module testbench;

   localparam int LIST_DEPTH  = bal_pkg::CAPACITY_DEF;
   localparam int ITEM_TOTAL  = 850;
   localparam int HOLD_CYCLES = 80;
   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 40;
   localparam int PRINT_LIMIT = 40;

   typedef struct {
      bal_pkg::req_kind_type kind;
      logic signed [31:0]    value;
      bit                    drain_first;
      bit                    hold_rsp;
   } list_req_type;

   typedef struct {
      bal_pkg::status_type   status;
      logic                  found;
      logic [3:0]            position;
      logic signed [31:0]    removed_value;
      logic [4:0]            item_count;
      logic signed [31:0]    sum_of_items;
   } list_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_type = bal_pkg::REQ_APPEND;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic               rsp_found;
   logic [3:0]         rsp_position;
   logic signed [31:0] rsp_removed_value;
   logic [4:0]         rsp_item_count;
   logic signed [31:0] rsp_sum_of_items;

   list_req_type       pending_q[$];
   list_rsp_type       expected_q[$];
   logic signed [31:0] shadow_list[$];
   logic signed [31:0] shadow_sum = '0;
   logic signed [31:0] value_pool[8];
   list_req_type       live_req;
   logic               hold_start = 1'b0;

   int queued_total    = 0;
   int predicted_total = 0;
   int checked_total   = 0;
   int mismatch_count  = 0;
   int refused_full    = 0;
   int removed_empty   = 0;
   int search_hits     = 0;
   int burst_left      = 0;
   int gap_left        = 0;
   int hold_left       = 0;
   int stall_mode      = 0;
   int mode_left       = 0;
   int idle_cycles     = 0;

   bounded_array_list #(
      .CAPACITY(LIST_DEPTH)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_position     (rsp_position),
      .rsp_removed_value(rsp_removed_value),
      .rsp_item_count   (rsp_item_count),
      .rsp_sum_of_items (rsp_sum_of_items)
   );

   always #2 clock = ~clock;

   function automatic list_rsp_type predict_list(list_req_type r);
      list_rsp_type o;
      o.status        = bal_pkg::STATUS_OK;
      o.found         = 1'b0;
      o.position      = '0;
      o.removed_value = '0;
      case (r.kind)
         bal_pkg::REQ_APPEND: begin
            if (shadow_list.size() >= LIST_DEPTH) begin
               o.status = bal_pkg::STATUS_FULL;
               refused_full++;
            end else begin
               shadow_list.push_back(r.value);
               shadow_sum += r.value;
            end
         end
         bal_pkg::REQ_REMOVE_LAST: begin
            if (shadow_list.size() == 0) begin
               o.status = bal_pkg::STATUS_EMPTY;
               removed_empty++;
            end else begin
               o.position      = 4'(shadow_list.size() - 1);
               o.removed_value = shadow_list.pop_back();
               shadow_sum     -= o.removed_value;
            end
         end
         bal_pkg::REQ_REMOVE_FIRST: begin
            if (shadow_list.size() == 0) begin
               o.status = bal_pkg::STATUS_EMPTY;
               removed_empty++;
            end else begin
               o.removed_value = shadow_list.pop_front();
               shadow_sum     -= o.removed_value;
            end
         end
         default: begin
            for (int i = 0; i < shadow_list.size(); i++) begin
               if (!o.found && shadow_list[i] == r.value) begin
                  o.found    = 1'b1;
                  o.position = 4'(i);
               end
            end
            if (o.found) search_hits++;
         end
      endcase
      o.item_count   = 5'(shadow_list.size());
      o.sum_of_items = shadow_sum;
      return o;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got 0x%h want 0x%h",
                                   checked_total, name, got, want));
   endtask

   task automatic add_req(input bal_pkg::req_kind_type kind,
                          input logic signed [31:0] value,
                          input bit drain_first, input bit hold_rsp);
      list_req_type r;
      r.kind        = kind;
      r.value       = value;
      r.drain_first = drain_first;
      r.hold_rsp    = hold_rsp;
      pending_q.push_back(r);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return value_pool[$urandom_range(0, 7)];
         5:             return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default:       return $urandom;
      endcase
   endfunction

   // driver: predict on the accepted beat, then offer the next one
   always @(posedge clock) begin
      logic         fire;
      logic         pulse;
      list_req_type nxt;
      pulse = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
         req_type  <= bal_pkg::REQ_APPEND;
         req_value <= '0;
      end else begin
         fire = req_valid && !req_stall;
         if (fire) begin
            expected_q.push_back(predict_list(live_req));
            predicted_total++;
         end
         if (!req_valid || fire) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q.size() == 0 ||
                         (pending_q[0].drain_first && predicted_total != checked_total)) begin
               req_valid <= 1'b0;
            end else begin
               nxt       = pending_q.pop_front();
               live_req  = nxt;
               pulse     = nxt.hold_rsp;
               req_valid <= 1'b1;
               req_type  <= nxt.kind;
               req_value <= nxt.value;
               if (burst_left == 0) burst_left = $urandom_range(1, 24);
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
      hold_start <= pulse;
   end

   // receiver stall pattern, with a long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_start) hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               mode_left  = $urandom_range(20, 120);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 2) == 0);
               default: rsp_stall <= ($urandom_range(0, 9) < 7);
            endcase
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = expected_q.pop_front();
            check_field("status", rsp_status, want.status);
            check_field("found", rsp_found, want.found);
            check_field("position", rsp_position, want.position);
            check_field("removed_value", rsp_removed_value, want.removed_value);
            check_field("item_count", rsp_item_count, want.item_count);
            check_field("sum_of_items", rsp_sum_of_items, want.sum_of_items);
            checked_total <= checked_total + 1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_q.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      logic signed [31:0] corner_vals[16];
      int kind_pick;

      corner_vals = '{
         32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF,
         32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0001, 32'sh7FFF_FFFF,
         32'sh0000_000C, 32'shFFFF_FFF4, 32'sh1234_5678, 32'shEDCB_A988,
         32'sh0F0F_0F0F, 32'shF0F0_F0F0, 32'sh4000_0000, 32'sh3C3C_A5A5
      };
      value_pool[0] = 32'sh0;
      value_pool[1] = -32'sd1;
      value_pool[2] = 32'sh7FFF_FFFF;
      value_pool[3] = 32'sh8000_0000;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

      // directed: empty list, fill to capacity, full, deep search, removals
      add_req(bal_pkg::REQ_REMOVE_LAST, 32'sh0, 1'b0, 1'b0);
      add_req(bal_pkg::REQ_REMOVE_FIRST, 32'sh0, 1'b0, 1'b0);
      add_req(bal_pkg::REQ_SEARCH, 32'sh0, 1'b0, 1'b0);
      for (int i = 0; i < 16; i++)
         add_req(bal_pkg::REQ_APPEND, corner_vals[i], 1'b0, i == 4);
      add_req(bal_pkg::REQ_APPEND, 32'sh1357_9BDF, 1'b0, 1'b0);
      add_req(bal_pkg::REQ_SEARCH, corner_vals[15], 1'b0, 1'b0);
      add_req(bal_pkg::REQ_SEARCH, 32'sh7FFF_FFFF, 1'b0, 1'b0);
      add_req(bal_pkg::REQ_SEARCH, 32'sh0BAD_F00D, 1'b0, 1'b0);
      add_req(bal_pkg::REQ_REMOVE_FIRST, 32'sh0, 1'b0, 1'b0);
      add_req(bal_pkg::REQ_REMOVE_LAST, 32'sh0, 1'b0, 1'b0);

      // random: fill runs, drain runs and mixed traffic
      add_req(bal_pkg::REQ_SEARCH, value_pool[2], 1'b1, 1'b0);
      while (pending_q.size() < ITEM_TOTAL) begin
         kind_pick = $urandom_range(0, 9);
         repeat ($urandom_range(4, 18)) begin
            if (kind_pick < 4)
               add_req(($urandom_range(0, 4) == 0) ? bal_pkg::REQ_SEARCH :
                       bal_pkg::REQ_APPEND,
                       pick_value(), $urandom_range(0, 99) == 0,
                       $urandom_range(0, 249) == 0);
            else if (kind_pick < 7)
               add_req(($urandom_range(0, 4) == 0) ? bal_pkg::REQ_SEARCH :
                       ($urandom_range(0, 1) ? bal_pkg::REQ_REMOVE_LAST :
                        bal_pkg::REQ_REMOVE_FIRST),
                       pick_value(), $urandom_range(0, 99) == 0,
                       $urandom_range(0, 249) == 0);
            else
               add_req(bal_pkg::req_kind_type'($urandom_range(0, 3)), pick_value(),
                       $urandom_range(0, 99) == 0, $urandom_range(0, 249) == 0);
         end
      end
      queued_total = pending_q.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (predicted_total != queued_total || checked_total != queued_total)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

      $display("covered %0d requests and %0d checked results", predicted_total, checked_total);
      $display("%0d appends refused as full, %0d removals on an empty list, %0d search hits",
               refused_full, removed_empty, search_hits);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
